@@ hw/rtl/bmts_pkg.sv @@
// ----------------------------------------------------------------------------
// bmts_pkg
// Types and constants of the bigram Markov table sampler.
// ----------------------------------------------------------------------------
package bmts_pkg;

   localparam logic [2:0] KIND_TRAIN  = 3'd0;
   localparam logic [2:0] KIND_NORM   = 3'd1;
   localparam logic [2:0] KIND_FIRST  = 3'd2;
   localparam logic [2:0] KIND_NEXT   = 3'd3;
   localparam logic [2:0] KIND_LENGTH = 3'd4;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_NONE = 1'b1;

   localparam logic [15:0] SCALE_RESET = 16'd1000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  symbol;
      logic        last_in_word;
      logic        clear_first;
      logic [31:0] random_value;
   } req_type;

   typedef struct packed {
      logic [7:0] picked_symbol;
      logic [5:0] picked_length;
      logic       status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TRAIN_RD,
      ST_TRAIN_WR,
      ST_SUM,
      ST_DIV,
      ST_SCAN,
      ST_NORM_RD,
      ST_NORM_MUL,
      ST_NORM_WR,
      ST_RESP
   } st_type;

endpackage

@@ hw/rtl/bigram_markov_table_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// bigram_markov_table_sampler_unit
// Learns symbol pair counts and word lengths, rescales them, and samples.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake            | payload
//   req      | in  | req_valid/req_ready  | req_data (req_type)
//   rsp      | out | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//   csr      | in  | csr_valid/csr_ready  | csr_data (norm_scale)
//
// training reads the pair and length counts and writes them back; a pick walks
// a row twice, with one divider pass between the walks for the modulo
// normalize sums each row, and for a rescaled row divides each entry in the
// bit-serial divider
// after reset and on a clear request the pair memory is swept, one entry a
// cycle; requests wait, csr writes do not
// one request at a time; the result register lets the next request in
module bigram_markov_table_sampler_unit
   import bmts_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256,
   parameter int MAX_WORD_LEN  = 64,
   parameter int COUNT_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int SYM_W   = $clog2(ALPHABET_SIZE);
   localparam int LEN_W   = $clog2(MAX_WORD_LEN);
   localparam int IDX_W   = (SYM_W > LEN_W) ? SYM_W : LEN_W;
   localparam int PAIR_AW = 2 * SYM_W;
   localparam int CLR_W   = (PAIR_AW > LEN_W) ? PAIR_AW : LEN_W;
   localparam int SUM_W   = COUNT_WIDTH + 8;
   localparam int DIV_W   = (COUNT_WIDTH + 16 > 32) ? COUNT_WIDTH + 16 : 32;
   localparam int DCNT_W  = $clog2(DIV_W);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] pair_mem [2**PAIR_AW];
   logic [COUNT_WIDTH-1:0] len_mem  [MAX_WORD_LEN];
   logic                   ne_mem   [ALPHABET_SIZE];

   st_type               state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic [7:0]           sym_ff, sym_in;
   logic                 last_ff, last_in;
   logic [31:0]          rnd_ff, rnd_in;
   logic                 pend_ff, pend_in;
   logic [SYM_W-1:0]     prev_ff, prev_in;
   logic [6:0]           wpos_ff, wpos_in;
   logic [LEN_W-1:0]     bin_ff, bin_in;
   logic [CLR_W-1:0]     clr_ff, clr_in;
   logic [SYM_W-1:0]     row_ff, row_in;
   logic                 len_sel_ff, len_sel_in;
   logic [IDX_W:0]       cnt_ff, cnt_in;
   logic                 vld_ff, vld_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SUM_W-1:0]     total_ff, total_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     r_ff, r_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic                 status_ff, status_in;
   logic                 any_ff, any_in;
   logic [DIV_W-1:0]     dq_ff, dq_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [15:0]          scale_ff, scale_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0] pair_rd_ff, len_rd_ff;
   logic                   ne_rd_ff;
   logic                   pair_we, len_we, ne_we;
   logic [PAIR_AW-1:0]     pair_waddr, pair_raddr;
   logic [LEN_W-1:0]       len_waddr, len_raddr;
   logic [SYM_W-1:0]       ne_waddr;
   logic [COUNT_WIDTH-1:0] pair_wdata, len_wdata;
   logic                   ne_wdata;

   logic [IDX_W:0]         lim;
   logic                   walk_issue, walk_done;
   logic [SUM_W-1:0]       weight, sum_add, acc_add;
   logic [SUM_W:0]         rem2;
   logic                   ge;
   logic [SUM_W-1:0]       rem_step;
   logic [DIV_W-1:0]       dq_step;
   logic                   sym_ok;
   logic [6:0]             wpos_new;
   logic [LEN_W-1:0]       bin;
   logic [COUNT_WIDTH-1:0] norm_data, quot;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      lim = ((op_ff == KIND_LENGTH) || ((op_ff == KIND_NORM) && len_sel_ff))
            ? (IDX_W+1)'(MAX_WORD_LEN) : (IDX_W+1)'(ALPHABET_SIZE);
      walk_issue = (cnt_ff < lim);
      walk_done  = !walk_issue && !vld_ff;
      unique case (op_ff)
         KIND_FIRST:  weight = ne_rd_ff ? SUM_W'(1) : '0;
         KIND_NEXT:   weight = ne_rd_ff ? SUM_W'(pair_rd_ff) : '0;
         KIND_LENGTH: weight = SUM_W'(len_rd_ff);
         KIND_NORM:   weight = len_sel_ff ? SUM_W'(len_rd_ff) : SUM_W'(pair_rd_ff);
         default:     weight = '0;
      endcase
      sum_add = total_ff + weight;
      acc_add = acc_ff + weight;
      // restoring divider, one quotient bit a cycle
      rem2     = {rem_ff, dq_ff[DIV_W-1]};
      ge       = (rem2 >= {1'b0, total_ff});
      rem_step = ge ? SUM_W'(rem2 - {1'b0, total_ff}) : rem2[SUM_W-1:0];
      dq_step  = {dq_ff[DIV_W-2:0], ge};
      sym_ok   = ({1'b0, sym_ff} < 9'(ALPHABET_SIZE));
      wpos_new = (wpos_ff < 7'd127) ? wpos_ff + 7'd1 : 7'd127;
      bin      = (wpos_new > 7'(MAX_WORD_LEN - 1)) ? LEN_W'(MAX_WORD_LEN - 1)
                                                   : wpos_new[LEN_W-1:0];
      norm_data = len_sel_ff ? len_rd_ff : pair_rd_ff;
      quot      = dq_ff[COUNT_WIDTH-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      sym_in      = sym_ff;
      last_in     = last_ff;
      rnd_in      = rnd_ff;
      pend_in     = pend_ff;
      prev_in     = prev_ff;
      wpos_in     = wpos_ff;
      bin_in      = bin_ff;
      clr_in      = clr_ff;
      row_in      = row_ff;
      len_sel_in  = len_sel_ff;
      cnt_in      = cnt_ff;
      vld_in      = vld_ff;
      idx_in      = idx_ff;
      total_in    = total_ff;
      acc_in      = acc_ff;
      r_in        = r_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      status_in   = status_ff;
      any_in      = any_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      dcnt_in     = dcnt_ff;
      scale_in    = csr_valid ? csr_data : scale_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pair_we    = 1'b0;
      pair_waddr = '0;
      pair_wdata = '0;
      pair_raddr = {row_ff, cnt_ff[SYM_W-1:0]};
      len_we     = 1'b0;
      len_waddr  = '0;
      len_wdata  = '0;
      len_raddr  = cnt_ff[LEN_W-1:0];
      ne_we      = 1'b0;
      ne_waddr   = '0;
      ne_wdata   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            pair_we    = 1'b1;
            pair_waddr = clr_ff[PAIR_AW-1:0];
            len_we     = ({1'b0, clr_ff} < (CLR_W+1)'(MAX_WORD_LEN));
            len_waddr  = clr_ff[LEN_W-1:0];
            ne_we      = ({1'b0, clr_ff} < (CLR_W+1)'(ALPHABET_SIZE));
            ne_waddr   = clr_ff[SYM_W-1:0];
            clr_in     = clr_ff + CLR_W'(1);
            if (&clr_ff) begin
               state_in = pend_ff ? ST_TRAIN_RD : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.kind;
               sym_in    = req_data.symbol;
               last_in   = req_data.last_in_word;
               rnd_in    = req_data.random_value;
               status_in = STATUS_DONE;
               pick_in   = '0;
               cnt_in    = '0;
               vld_in    = 1'b0;
               total_in  = '0;
               len_sel_in = 1'b0;
               unique case (req_data.kind)
                  KIND_TRAIN: begin
                     if (req_data.clear_first) begin
                        clr_in      = '0;
                        prev_in     = '0;
                        wpos_in     = '0;
                        pend_in     = 1'b1;
                        state_in    = ST_CLEAR;
                     end else begin
                        state_in = ST_TRAIN_RD;
                     end
                  end
                  KIND_NORM: begin
                     row_in   = '0;
                     state_in = ST_SUM;
                  end
                  KIND_FIRST, KIND_LENGTH: state_in = ST_SUM;
                  KIND_NEXT: begin
                     if ({1'b0, req_data.symbol} < 9'(ALPHABET_SIZE)) begin
                        row_in   = req_data.symbol[SYM_W-1:0];
                        state_in = ST_SUM;
                     end else begin
                        status_in = STATUS_NONE;
                        state_in  = ST_RESP;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_TRAIN_RD: begin
            pair_raddr = {prev_ff, sym_ff[SYM_W-1:0]};
            len_raddr  = bin;
            bin_in     = bin;
            state_in   = sym_ok ? ST_TRAIN_WR : ST_RESP;
         end
         ST_TRAIN_WR: begin
            if (wpos_ff != 7'd0) begin
               pair_we    = 1'b1;
               pair_waddr = {prev_ff, sym_ff[SYM_W-1:0]};
               pair_wdata = (pair_rd_ff == CNT_MAX) ? pair_rd_ff
                                                    : pair_rd_ff + COUNT_WIDTH'(1);
               ne_we      = 1'b1;
               ne_waddr   = prev_ff;
               ne_wdata   = 1'b1;
            end
            prev_in = sym_ff[SYM_W-1:0];
            if (last_ff) begin
               len_we    = 1'b1;
               len_waddr = bin_ff;
               len_wdata = (len_rd_ff == CNT_MAX) ? len_rd_ff
                                                  : len_rd_ff + COUNT_WIDTH'(1);
               wpos_in   = 7'd0;
            end else begin
               wpos_in = wpos_new;
            end
            state_in = ST_RESP;
         end
         ST_SUM: begin
            if (walk_issue) begin
               cnt_in = cnt_ff + (IDX_W+1)'(1);
               idx_in = cnt_ff[IDX_W-1:0];
            end
            vld_in = walk_issue;
            if (vld_ff) begin
               total_in = sum_add;
            end
            if (walk_done) begin
               cnt_in = '0;
               any_in = 1'b0;
               if (op_ff == KIND_NORM) begin
                  if (len_sel_ff) begin
                     state_in = (total_ff != '0) ? ST_NORM_RD : ST_RESP;
                  end else if (total_ff > SUM_W'(scale_ff)) begin
                     state_in = ST_NORM_RD;
                  end else begin
                     ne_we    = 1'b1;
                     ne_waddr = row_ff;
                     ne_wdata = (total_ff != '0);
                     total_in = '0;
                     if (row_ff == SYM_W'(ALPHABET_SIZE - 1)) begin
                        len_sel_in = 1'b1;
                     end else begin
                        row_in = row_ff + SYM_W'(1);
                     end
                  end
               end else if (total_ff == '0) begin
                  status_in = STATUS_NONE;
                  state_in  = ST_RESP;
               end else begin
                  dq_in    = DIV_W'(rnd_ff);
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            dq_in   = dq_step;
            rem_in  = rem_step;
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_W - 1)) begin
               if (op_ff == KIND_NORM) begin
                  state_in = ST_NORM_WR;
               end else begin
                  r_in     = rem_step;
                  cnt_in   = '0;
                  vld_in   = 1'b0;
                  acc_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (walk_issue) begin
               cnt_in = cnt_ff + (IDX_W+1)'(1);
               idx_in = cnt_ff[IDX_W-1:0];
            end
            vld_in = walk_issue;
            if (vld_ff) begin
               acc_in = acc_add;
               if (!found_ff && (acc_add > r_ff)) begin
                  pick_in  = idx_ff;
                  found_in = 1'b1;
               end
            end
            if (walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_NORM_RD: begin
            if (walk_issue) begin
               cnt_in   = cnt_ff + (IDX_W+1)'(1);
               idx_in   = cnt_ff[IDX_W-1:0];
               state_in = ST_NORM_MUL;
            end else if (len_sel_ff) begin
               state_in = ST_RESP;
            end else begin
               // row done, move on to the next row or the length histogram
               ne_we    = 1'b1;
               ne_waddr = row_ff;
               ne_wdata = any_ff;
               cnt_in   = '0;
               vld_in   = 1'b0;
               total_in = '0;
               state_in = ST_SUM;
               if (row_ff == SYM_W'(ALPHABET_SIZE - 1)) begin
                  len_sel_in = 1'b1;
               end else begin
                  row_in = row_ff + SYM_W'(1);
               end
            end
         end
         ST_NORM_MUL: begin
            dq_in    = DIV_W'(norm_data) * DIV_W'(scale_ff);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_NORM_WR: begin
            if (len_sel_ff) begin
               len_we    = 1'b1;
               len_waddr = idx_ff[LEN_W-1:0];
               len_wdata = quot;
            end else begin
               pair_we    = 1'b1;
               pair_waddr = {row_ff, idx_ff[SYM_W-1:0]};
               pair_wdata = quot;
            end
            any_in   = any_ff || (quot != '0);
            state_in = ST_NORM_RD;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.picked_symbol = ((op_ff == KIND_FIRST) || (op_ff == KIND_NEXT))
                                           ? 8'(pick_ff) : 8'd0;
               rsp_data_in.picked_length = (op_ff == KIND_LENGTH) ? 6'(pick_ff) : 6'd0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pair_we) begin
         pair_mem[pair_waddr] <= pair_wdata;
      end
      pair_rd_ff <= pair_mem[pair_raddr];
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rd_ff <= len_mem[len_raddr];
      if (ne_we) begin
         ne_mem[ne_waddr] <= ne_wdata;
      end
      ne_rd_ff <= ne_mem[cnt_ff[SYM_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         prev_ff      <= '0;
         wpos_ff      <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         prev_ff      <= prev_in;
         wpos_ff      <= wpos_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      rnd_ff      <= rnd_in;
      bin_ff      <= bin_in;
      row_ff      <= row_in;
      len_sel_ff  <= len_sel_in;
      cnt_ff      <= cnt_in;
      vld_ff      <= vld_in;
      idx_ff      <= idx_in;
      total_ff    <= total_in;
      acc_ff      <= acc_in;
      r_ff        <= r_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      status_ff   <= status_in;
      any_ff      <= any_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bigram Markov table sampler. A table of directed requests
// covers the empty tables, unused kinds, clears and both extremes of the
// random word. Random word-shaped training runs, mixed with picks and rare
// normalize commands, follow under several scale settings. Each result is
// checked field by field against its fixed row or the pair and length predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import bmts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NSYM       = 256;
   localparam int          NLEN       = 64;
   localparam int          CNT_MAX    = 65535;
   localparam logic [2:0]  KIND_SPARE5 = 3'd5;
   localparam logic [2:0]  KIND_SPARE6 = 3'd6;
   localparam logic [2:0]  KIND_SPARE7 = 3'd7;
   localparam longint      CYCLE_LIMIT = 60_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [15:0] csr_data = '0;

   bigram_markov_table_sampler_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   bit [15:0] pair_cnt [NSYM][NSYM];
   bit        row_used [NSYM];
   bit [15:0] len_cnt [NLEN];
   bit [7:0]  prev_sym;
   int        word_pos;
   bit [15:0] scale;

   rsp_type pending_rsp[$];
   int      error_count = 0;
   bit      quiet = 1'b0;
   longint  cycles = 0;

   task automatic report(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic void clear_tables();
      foreach (pair_cnt[r, c]) pair_cnt[r][c] = '0;
      foreach (row_used[r]) row_used[r] = 1'b0;
      foreach (len_cnt[i]) len_cnt[i] = '0;
      prev_sym = '0;
      word_pos = 0;
   endfunction

   function automatic bit [15:0] bump(input bit [15:0] v);
      return (v == CNT_MAX) ? v : v + 16'd1;
   endfunction

   function automatic void rescale_tables();
      longint total;
      bit     any;
      for (int r = 0; r < NSYM; r++) begin
         total = 0;
         any = 1'b0;
         for (int c = 0; c < NSYM; c++) total += pair_cnt[r][c];
         if (total > scale) begin
            for (int c = 0; c < NSYM; c++)
               pair_cnt[r][c] = 16'((longint'(pair_cnt[r][c]) * scale) / total);
         end
         for (int c = 0; c < NSYM; c++) if (pair_cnt[r][c] != 0) any = 1'b1;
         row_used[r] = any;
      end
      total = 0;
      for (int i = 0; i < NLEN; i++) total += len_cnt[i];
      if (total != 0) begin
         for (int i = 0; i < NLEN; i++)
            len_cnt[i] = 16'((longint'(len_cnt[i]) * scale) / total);
      end
   endfunction

   function automatic rsp_type predict_sample(input req_type q);
      rsp_type o;
      longint  total, acc, pick;
      int      bin;
      o = '0;
      o.status = STATUS_DONE;
      total = 0;
      acc = 0;
      case (q.kind)
         KIND_TRAIN: begin
            if (q.clear_first) clear_tables();
            if (word_pos != 0) begin
               pair_cnt[prev_sym][q.symbol] = bump(pair_cnt[prev_sym][q.symbol]);
               row_used[prev_sym] = 1'b1;
            end
            prev_sym = q.symbol;
            if (word_pos < 127) word_pos++;
            if (q.last_in_word) begin
               bin = (word_pos > NLEN - 1) ? NLEN - 1 : word_pos;
               len_cnt[bin] = bump(len_cnt[bin]);
               word_pos = 0;
            end
         end
         KIND_NORM: rescale_tables();
         KIND_FIRST: begin
            for (int i = 0; i < NSYM; i++) total += row_used[i];
            if (total == 0) o.status = STATUS_NONE;
            else begin
               pick = q.random_value % total;
               for (int i = 0; i < NSYM; i++) begin
                  if (row_used[i]) begin
                     if (acc == pick) begin
                        o.picked_symbol = 8'(i);
                        break;
                     end
                     acc++;
                  end
               end
            end
         end
         KIND_NEXT: begin
            for (int i = 0; i < NSYM; i++)
               if (row_used[i]) total += pair_cnt[q.symbol][i];
            if (total == 0) o.status = STATUS_NONE;
            else begin
               pick = q.random_value % total;
               for (int i = 0; i < NSYM; i++) begin
                  if (row_used[i]) begin
                     acc += pair_cnt[q.symbol][i];
                     if (acc > pick) begin
                        o.picked_symbol = 8'(i);
                        break;
                     end
                  end
               end
            end
         end
         KIND_LENGTH: begin
            for (int i = 0; i < NLEN; i++) total += len_cnt[i];
            if (total == 0) o.status = STATUS_NONE;
            else begin
               pick = q.random_value % total;
               for (int i = 0; i < NLEN; i++) begin
                  acc += len_cnt[i];
                  if (acc > pick) begin
                     o.picked_length = 6'(i);
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // one request through the handshake; fixed rows bring their own expectation
   task automatic send(input req_type q, input bit fixed = 1'b0,
                       input rsp_type typed = '0);
      rsp_type p;
      req_data <= q;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_sample(q);
      pending_rsp.insert(pending_rsp.size(), fixed ? typed : p);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_scale(input bit [15:0] v);
      drain();
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scale = v;
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk(input logic [2:0] k, input logic [7:0] s,
                                  input logic l, input logic c,
                                  input logic [31:0] rv);
      req_type q;
      q.kind = k;
      q.symbol = s;
      q.last_in_word = l;
      q.clear_first = c;
      q.random_value = rv;
      return q;
   endfunction

   function automatic rsp_type rs(input logic [7:0] s, input logic [5:0] l,
                                  input logic st);
      rsp_type o;
      o.picked_symbol = s;
      o.picked_length = l;
      o.status = st;
      return o;
   endfunction

   typedef struct {
      req_type q;
      bit      fixed;
      rsp_type e;
   } row_type;

   row_type drows[$];

   task automatic add(input req_type q, input bit fixed = 1'b0,
                      input rsp_type e = '0);
      row_type d;
      d.q = q;
      d.fixed = fixed;
      d.e = e;
      drows.insert(drows.size(), d);
   endtask

   // random word-shaped traffic over a small symbol pool
   task automatic random_phase(input int n_items, input int norm_budget,
                               input bit long_word);
      int  sent, len, sel;
      logic [7:0] pool [12];
      logic [7:0] s;
      foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
      sent = 0;
      if (long_word) begin
         for (int i = 0; i < 130; i++)
            send(mk(KIND_TRAIN, pool[i % 12], i == 129, 1'b0, $urandom()));
         sent += 130;
      end
      while (sent < n_items) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
                                               : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               s = ($urandom_range(0, 9) == 0) ? 8'($urandom()) :
                   pool[$urandom_range(0, 11)];
               // a few words are left unterminated and run into the next one
               send(mk(KIND_TRAIN, s,
                       i == len - 1 && $urandom_range(0, 15) != 0,
                       i == 0 && $urandom_range(0, 199) == 0, $urandom()));
            end
            sent += len;
         end else if (sel < 97) begin
            s = ($urandom_range(0, 4) == 0) ? 8'($urandom()) :
                pool[$urandom_range(0, 11)];
            send(mk(3'($urandom_range(KIND_FIRST, KIND_LENGTH)), s,
                    1'($urandom()), 1'($urandom()), $urandom()));
            sent++;
         end else if (sel < 99) begin
            send(mk(3'($urandom_range(KIND_SPARE5, KIND_SPARE7)), 8'($urandom()),
                    1'($urandom()), 1'($urandom()), $urandom()));
            sent++;
         end else if (norm_budget > 0) begin
            norm_budget--;
            send(mk(KIND_NORM, 8'($urandom()), 1'b0, 1'b0, $urandom()));
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) report("result with nothing expected");
         else begin
            e = pending_rsp.pop_front();
            if (rsp_data.picked_symbol !== e.picked_symbol)
               report($sformatf("picked_symbol %0h, want %0h",
                                rsp_data.picked_symbol, e.picked_symbol));
            if (rsp_data.picked_length !== e.picked_length)
               report($sformatf("picked_length %0d, want %0d",
                                rsp_data.picked_length, e.picked_length));
            if (rsp_data.status !== e.status)
               report($sformatf("status %0b, want %0b", rsp_data.status, e.status));
         end
      end
   end

   // receiver stalls in bursts unless quiet is set
   initial begin
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   initial begin
      clear_tables();
      scale = SCALE_RESET;

      add(mk(KIND_FIRST, 8'h00, 1'b0, 1'b0, 32'h0), 1, rs(0, 0, STATUS_NONE));
      add(mk(KIND_NEXT, 8'h00, 1'b0, 1'b0, 32'h0), 1, rs(0, 0, STATUS_NONE));
      add(mk(KIND_LENGTH, 8'hff, 1'b1, 1'b1, 32'hffffffff), 1,
          rs(0, 0, STATUS_NONE));
      add(mk(KIND_SPARE5, 8'hff, 1'b1, 1'b1, 32'hffffffff), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_SPARE6, 8'h00, 1'b0, 1'b0, 32'h0), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_SPARE7, 8'h5a, 1'b1, 1'b0, 32'h12345678), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_NORM, 8'h00, 1'b0, 1'b0, 32'h0), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_TRAIN, 8'h41, 1'b0, 1'b0, 32'h0), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_TRAIN, 8'h42, 1'b0, 1'b0, 32'hffffffff), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_TRAIN, 8'hff, 1'b1, 1'b0, 32'h0), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_TRAIN, 8'h00, 1'b1, 1'b0, 32'h0), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_FIRST, 8'h00, 1'b0, 1'b0, 32'h0));
      add(mk(KIND_FIRST, 8'h00, 1'b0, 1'b0, 32'hffffffff));
      add(mk(KIND_NEXT, 8'h41, 1'b0, 1'b0, 32'h0));
      // successor row empty, so no choice
      add(mk(KIND_NEXT, 8'h42, 1'b0, 1'b0, 32'hffffffff));
      add(mk(KIND_LENGTH, 8'h00, 1'b0, 1'b0, 32'h0));
      add(mk(KIND_LENGTH, 8'h00, 1'b0, 1'b0, 32'hffffffff));
      add(mk(KIND_NORM, 8'h00, 1'b0, 1'b0, 32'h0));
      add(mk(KIND_TRAIN, 8'h01, 1'b1, 1'b1, 32'h0), 1, rs(0, 0, STATUS_DONE));
      add(mk(KIND_FIRST, 8'h00, 1'b0, 1'b0, 32'h0), 1, rs(0, 0, STATUS_NONE));
      add(mk(KIND_LENGTH, 8'h00, 1'b0, 1'b0, 32'h7), 1, rs(0, 1, STATUS_DONE));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (drows[i]) send(drows[i].q, drows[i].fixed, drows[i].e);

      write_scale(16'hffff);
      random_phase(250, 2, 1'b1);
      write_scale(16'd1);
      random_phase(150, 1, 1'b0);
      write_scale(16'($urandom_range(20, 5000)));
      random_phase(250, 3, 1'b0);
      write_scale(SCALE_RESET);
      quiet = 1'b1;
      random_phase(200, 2, 1'b0);

      drain();
      repeat (600) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/bmts_pkg.sv
hw/rtl/bigram_markov_table_sampler_unit.sv
test/tb_top.sv
